### hw/rtl/sic_pkg.sv
package sic_pkg;

  // Default geometry
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 8;

  // Fraction bits of the t and s parameters
  localparam int unsigned T_FRAC = 16;

  // Result field width
  localparam int unsigned OUT_W = 32;

  typedef enum logic [1:0] {
    KIND_INSIDE   = 2'd0,
    KIND_BEYOND   = 2'd1,
    KIND_PARALLEL = 2'd2
  } kind_e;

endpackage

### hw/rtl/sic_front.sv
module sic_front
  import sic_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [COORD_BITS-1:0]         a_x0_i,
  input  logic [COORD_BITS-1:0]         a_y0_i,
  input  logic [COORD_BITS-1:0]         a_x1_i,
  input  logic [COORD_BITS-1:0]         a_y1_i,
  input  logic [COORD_BITS-1:0]         b_x0_i,
  input  logic [COORD_BITS-1:0]         b_y0_i,
  input  logic [COORD_BITS-1:0]         b_x1_i,
  input  logic [COORD_BITS-1:0]         b_y1_i,
  output logic                          valid_o,
  output logic [2*COORD_BITS:0]         den_o,
  output logic [2*COORD_BITS+T_FRAC:0]  tnum_o,
  output logic [2*COORD_BITS+T_FRAC:0]  snum_o,
  output logic [2*(COORD_BITS+FRAC_BITS+1)-1:0] rada_o,
  output logic [2*(COORD_BITS+FRAC_BITS+1)-1:0] radb_o,
  output logic [4*COORD_BITS+5:0]       sb_o
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned DW  = 2*C+1;
  localparam int unsigned QW  = DW+T_FRAC;
  localparam int unsigned SW  = C+FRAC_BITS+1;
  localparam int unsigned SBW = 4*C+6;
  localparam int unsigned PW  = 2*C+2;
  localparam int unsigned NW  = 2*C+3;

  // Stage A: edge vectors
  logic                a_vld_q;
  logic signed [C:0]   d1x_q, d1y_q, d2x_q, d2y_q, ex_q, ey_q;
  logic [C-1:0]        ax0_a_q, ay0_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d1x_q   <= $signed({1'b0, a_x1_i}) - $signed({1'b0, a_x0_i});
      d1y_q   <= $signed({1'b0, a_y1_i}) - $signed({1'b0, a_y0_i});
      d2x_q   <= $signed({1'b0, b_x1_i}) - $signed({1'b0, b_x0_i});
      d2y_q   <= $signed({1'b0, b_y1_i}) - $signed({1'b0, b_y0_i});
      ex_q    <= $signed({1'b0, a_x0_i}) - $signed({1'b0, b_x0_i});
      ey_q    <= $signed({1'b0, a_y0_i}) - $signed({1'b0, b_y0_i});
      ax0_a_q <= a_x0_i;
      ay0_a_q <= a_y0_i;
    end
  end

  // Stage B: cross products and squares
  logic                b_vld_q;
  logic signed [PW-1:0] pd1_q, pd2_q, pt1_q, pt2_q, ps1_q, ps2_q;
  logic signed [PW-1:0] qa1_q, qa2_q, qb1_q, qb2_q;
  logic signed [C:0]   d1x_b_q, d1y_b_q;
  logic [C-1:0]        ax0_b_q, ay0_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pd1_q   <= d1x_q * d2y_q;
      pd2_q   <= d2x_q * d1y_q;
      pt1_q   <= d2x_q * ey_q;
      pt2_q   <= d2y_q * ex_q;
      ps1_q   <= d1x_q * ey_q;
      ps2_q   <= d1y_q * ex_q;
      qa1_q   <= d1x_q * d1x_q;
      qa2_q   <= d1y_q * d1y_q;
      qb1_q   <= d2x_q * d2x_q;
      qb2_q   <= d2y_q * d2y_q;
      d1x_b_q <= d1x_q;
      d1y_b_q <= d1y_q;
      ax0_b_q <= ax0_a_q;
      ay0_b_q <= ay0_a_q;
    end
  end

  // Stage C: determinant, numerators, squared lengths
  logic                c_vld_q;
  logic signed [NW-1:0] det_q, tn_q, sn_q;
  logic [DW-1:0]       l2a_q, l2b_q;
  logic signed [C:0]   d1x_c_q, d1y_c_q;
  logic [C-1:0]        ax0_c_q, ay0_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv_i) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      det_q   <= NW'(pd1_q) - NW'(pd2_q);
      tn_q    <= NW'(pt1_q) - NW'(pt2_q);
      sn_q    <= NW'(ps1_q) - NW'(ps2_q);
      l2a_q   <= DW'(qa1_q[2*C-1:0]) + DW'(qa2_q[2*C-1:0]);
      l2b_q   <= DW'(qb1_q[2*C-1:0]) + DW'(qb2_q[2*C-1:0]);
      d1x_c_q <= d1x_b_q;
      d1y_c_q <= d1y_b_q;
      ax0_c_q <= ax0_b_q;
      ay0_c_q <= ay0_b_q;
    end
  end

  // Stage D: magnitudes, signs and the exact inside test
  logic signed [NW-1:0] nd, nsn, ntn, tn_mag, sn_mag;
  kind_e                kind;

  always_comb begin
    nd     = det_q[NW-1] ? -det_q : det_q;
    nsn    = det_q[NW-1] ? -sn_q  : sn_q;
    ntn    = det_q[NW-1] ? -tn_q  : tn_q;
    tn_mag = tn_q[NW-1] ? -tn_q : tn_q;
    sn_mag = sn_q[NW-1] ? -sn_q : sn_q;
    if (det_q == '0) begin
      kind = KIND_PARALLEL;
    end else if (!nsn[NW-1] && (nsn <= nd) && !ntn[NW-1] && (ntn <= nd)) begin
      kind = KIND_INSIDE;
    end else begin
      kind = KIND_BEYOND;
    end
  end

  logic          d_vld_q;
  logic [DW-1:0] den_q;
  logic [QW-1:0] tnum_q, snum_q;
  logic [2*SW-1:0] rada_q, radb_q;
  logic [SBW-1:0]  sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (adv_i) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      den_q  <= nd[DW-1:0];
      tnum_q <= {tn_mag[DW-1:0], {T_FRAC{1'b0}}};
      snum_q <= {sn_mag[DW-1:0], {T_FRAC{1'b0}}};
      rada_q <= {1'b0, l2a_q, {(2*FRAC_BITS){1'b0}}};
      radb_q <= {1'b0, l2b_q, {(2*FRAC_BITS){1'b0}}};
      sb_q   <= {kind, tn_q[NW-1] ^ det_q[NW-1], sn_q[NW-1] ^ det_q[NW-1],
                 ax0_c_q, ay0_c_q, d1x_c_q, d1y_c_q};
    end
  end

  assign valid_o = d_vld_q;
  assign den_o   = den_q;
  assign tnum_o  = tnum_q;
  assign snum_o  = snum_q;
  assign rada_o  = rada_q;
  assign radb_o  = radb_q;
  assign sb_o    = sb_q;

endmodule

### hw/rtl/sic_cell.sv
module sic_cell
  import sic_pkg::*;
#(
  parameter int unsigned DW      = 25,
  parameter int unsigned QW      = 41,
  parameter int unsigned SW      = 21,
  parameter int unsigned SBW     = 54,
  parameter bit          SQRT_ON = 1'b1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  logic [DW-1:0]   den_i,
  input  logic [DW-1:0]   t_rem_i,
  input  logic [QW-1:0]   t_nq_i,
  input  logic [DW-1:0]   s_rem_i,
  input  logic [QW-1:0]   s_nq_i,
  input  logic [SW+1:0]   a_rem_i,
  input  logic [2*SW-1:0] a_rad_i,
  input  logic [SW-1:0]   a_root_i,
  input  logic [SW+1:0]   b_rem_i,
  input  logic [2*SW-1:0] b_rad_i,
  input  logic [SW-1:0]   b_root_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            valid_o,
  output logic [DW-1:0]   den_o,
  output logic [DW-1:0]   t_rem_o,
  output logic [QW-1:0]   t_nq_o,
  output logic [DW-1:0]   s_rem_o,
  output logic [QW-1:0]   s_nq_o,
  output logic [SW+1:0]   a_rem_o,
  output logic [2*SW-1:0] a_rad_o,
  output logic [SW-1:0]   a_root_o,
  output logic [SW+1:0]   b_rem_o,
  output logic [2*SW-1:0] b_rad_o,
  output logic [SW-1:0]   b_root_o,
  output logic [SBW-1:0]  sb_o
);

  // One restoring divide step for t and for s
  logic [DW:0]   t_try, s_try;
  logic          t_ge, s_ge;
  logic [DW-1:0] t_rem_d, s_rem_d;
  logic [QW-1:0] t_nq_d, s_nq_d;

  always_comb begin
    t_try   = {t_rem_i, t_nq_i[QW-1]};
    s_try   = {s_rem_i, s_nq_i[QW-1]};
    t_ge    = t_try >= {1'b0, den_i};
    s_ge    = s_try >= {1'b0, den_i};
    t_rem_d = t_ge ? DW'(t_try - {1'b0, den_i}) : t_try[DW-1:0];
    s_rem_d = s_ge ? DW'(s_try - {1'b0, den_i}) : s_try[DW-1:0];
    t_nq_d  = {t_nq_i[QW-2:0], t_ge};
    s_nq_d  = {s_nq_i[QW-2:0], s_ge};
  end

  // One root digit for each segment length, or hold once done
  logic [SW+1:0]   a_rem_d, b_rem_d;
  logic [2*SW-1:0] a_rad_d, b_rad_d;
  logic [SW-1:0]   a_root_d, b_root_d;

  if (SQRT_ON) begin : g_sqrt
    logic [SW+3:0] a_try, b_try, a_trial, b_trial;
    logic          a_ge, b_ge;

    always_comb begin
      a_try    = {a_rem_i, a_rad_i[2*SW-1 -: 2]};
      b_try    = {b_rem_i, b_rad_i[2*SW-1 -: 2]};
      a_trial  = {2'b00, a_root_i, 2'b01};
      b_trial  = {2'b00, b_root_i, 2'b01};
      a_ge     = a_try >= a_trial;
      b_ge     = b_try >= b_trial;
      a_rem_d  = a_ge ? (SW+2)'(a_try - a_trial) : a_try[SW+1:0];
      b_rem_d  = b_ge ? (SW+2)'(b_try - b_trial) : b_try[SW+1:0];
      a_root_d = {a_root_i[SW-2:0], a_ge};
      b_root_d = {b_root_i[SW-2:0], b_ge};
      a_rad_d  = {a_rad_i[2*SW-3:0], 2'b00};
      b_rad_d  = {b_rad_i[2*SW-3:0], 2'b00};
    end
  end else begin : g_hold
    always_comb begin
      a_rem_d  = a_rem_i;
      b_rem_d  = b_rem_i;
      a_root_d = a_root_i;
      b_root_d = b_root_i;
      a_rad_d  = a_rad_i;
      b_rad_d  = b_rad_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      den_o    <= den_i;
      t_rem_o  <= t_rem_d;
      t_nq_o   <= t_nq_d;
      s_rem_o  <= s_rem_d;
      s_nq_o   <= s_nq_d;
      a_rem_o  <= a_rem_d;
      a_rad_o  <= a_rad_d;
      a_root_o <= a_root_d;
      b_rem_o  <= b_rem_d;
      b_rad_o  <= b_rad_d;
      b_root_o <= b_root_d;
      sb_o     <= sb_i;
    end
  end

endmodule

### hw/rtl/sic_back.sv
module sic_back
  import sic_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  logic [2*COORD_BITS+T_FRAC:0]        tq_i,
  input  logic [2*COORD_BITS+T_FRAC:0]        sq_i,
  input  logic [COORD_BITS+FRAC_BITS:0]       lena_i,
  input  logic [COORD_BITS+FRAC_BITS:0]       lenb_i,
  input  logic [4*COORD_BITS+5:0]             sb_i,
  output logic                                valid_o,
  output logic [1:0]                          kind_o,
  output logic signed [OUT_W-1:0]             cross_x_o,
  output logic signed [OUT_W-1:0]             cross_y_o,
  output logic [OUT_W-1:0]                    near_dist_a_o,
  output logic [OUT_W-1:0]                    near_dist_b_o
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned QW   = 2*C+1+T_FRAC;
  localparam int unsigned SW   = C+FRAC_BITS+1;
  localparam int unsigned LW   = QW+C-(T_FRAC-FRAC_BITS);
  localparam int unsigned EW   = ((LW > 41) ? LW : 41) + 1;
  localparam int unsigned DLW  = QW+SW-T_FRAC;
  localparam int unsigned DEW  = (DLW > 33) ? DLW : 33;
  localparam logic [QW-1:0] HALF = QW'(1) << (T_FRAC-1);
  localparam logic [QW-1:0] ONE  = QW'(1) << T_FRAC;
  localparam logic [EW-1:0] LIM  = EW'(64'd1 << 40);
  localparam logic signed [EW+1:0] VMAX = (EW+2)'(64'sd2147483647);
  localparam logic signed [EW+1:0] VMIN = (EW+2)'(-64'sd2147483648);

  // Sideband fields
  logic [1:0]        sb_kind;
  logic              sb_tneg, sb_sneg;
  logic [C-1:0]      sb_ax0, sb_ay0;
  logic signed [C:0] sb_d1x, sb_d1y;

  assign {sb_kind, sb_tneg, sb_sneg, sb_ax0, sb_ay0, sb_d1x, sb_d1y} = sb_i;

  // Distance to the nearer endpoint, in parameter units
  function automatic logic [QW-1:0] side_mag(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] r;
    if (neg || q <= HALF) begin
      r = q;
    end else if (q >= ONE) begin
      r = q - ONE;
    end else begin
      r = ONE - q;
    end
    return r;
  endfunction

  // Stage E1: side magnitudes and direction magnitudes
  logic              e1_vld_q;
  logic [QW-1:0]     tq_q, sa_q, sbm_q;
  logic [SW-1:0]     lena_q, lenb_q;
  logic [C-1:0]      dxm_q, dym_q;
  logic              negx_q, negy_q;
  logic [C-1:0]      ax0_q, ay0_q;
  logic [1:0]        kind_q;
  logic signed [C:0] dxn, dyn;

  assign dxn = sb_d1x[C] ? -sb_d1x : sb_d1x;
  assign dyn = sb_d1y[C] ? -sb_d1y : sb_d1y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q <= 1'b0;
    end else if (adv_i) begin
      e1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tq_q   <= tq_i;
      sa_q   <= side_mag(tq_i, sb_tneg);
      sbm_q  <= side_mag(sq_i, sb_sneg);
      lena_q <= lena_i;
      lenb_q <= lenb_i;
      dxm_q  <= dxn[C-1:0];
      dym_q  <= dyn[C-1:0];
      negx_q <= sb_tneg ^ sb_d1x[C];
      negy_q <= sb_tneg ^ sb_d1y[C];
      ax0_q  <= sb_ax0;
      ay0_q  <= sb_ay0;
      kind_q <= sb_kind;
    end
  end

  // Stage E2: products
  logic              e2_vld_q;
  logic [QW+C-1:0]   px_q, py_q;
  logic [QW+SW-1:0]  da_q, db_q;
  logic              negx2_q, negy2_q;
  logic [C-1:0]      ax0_2_q, ay0_2_q;
  logic [1:0]        kind2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_vld_q <= 1'b0;
    end else if (adv_i) begin
      e2_vld_q <= e1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px_q    <= (QW+C)'(tq_q) * (QW+C)'(dxm_q);
      py_q    <= (QW+C)'(tq_q) * (QW+C)'(dym_q);
      da_q    <= (QW+SW)'(sa_q) * (QW+SW)'(lena_q);
      db_q    <= (QW+SW)'(sbm_q) * (QW+SW)'(lenb_q);
      negx2_q <= negx_q;
      negy2_q <= negy_q;
      ax0_2_q <= ax0_q;
      ay0_2_q <= ay0_q;
      kind2_q <= kind_q;
    end
  end

  // Point coordinate: base plus signed offset, clamped to 32 bits
  function automatic logic [OUT_W-1:0] point(input logic [LW-1:0] lo, input logic neg,
                                             input logic [C-1:0] base);
    logic [EW-1:0]          lo_e;
    logic signed [EW+1:0]   off, v;
    logic [OUT_W-1:0]       r;
    lo_e = EW'(lo);
    off  = $signed({2'b00, lo_e});
    v    = (neg ? -off : off) + $signed((EW+2)'({base, {FRAC_BITS{1'b0}}}));
    if (lo_e > LIM) begin
      r = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (v > VMAX) begin
      r = 32'h7fff_ffff;
    end else if (v < VMIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] dist_sat(input logic [DLW-1:0] d);
    logic [DEW-1:0] e;
    e = DEW'(d);
    return (e[DEW-1:OUT_W] != '0) ? 32'hffff_ffff : e[OUT_W-1:0];
  endfunction

  // Output register
  logic              out_vld_q;
  logic [1:0]        kind_o_q;
  logic [OUT_W-1:0]  cx_q, cy_q, na_q, nb_q;
  logic              par;

  assign par = (kind2_q == KIND_PARALLEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      out_vld_q <= e2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind_o_q <= kind2_q;
      cx_q     <= par ? '0 : point(px_q[QW+C-1 -: LW], negx2_q, ax0_2_q);
      cy_q     <= par ? '0 : point(py_q[QW+C-1 -: LW], negy2_q, ay0_2_q);
      na_q     <= par ? '0 : dist_sat(da_q[QW+SW-1 -: DLW]);
      nb_q     <= par ? '0 : dist_sat(db_q[QW+SW-1 -: DLW]);
    end
  end

  assign valid_o       = out_vld_q;
  assign kind_o        = kind_o_q;
  assign cross_x_o     = $signed(cx_q);
  assign cross_y_o     = $signed(cy_q);
  assign near_dist_a_o = na_q;
  assign near_dist_b_o = nb_q;

endmodule

### hw/rtl/segment_intersection_core.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | a_x0..b_y1 (COORD_BITS each)
// out     | output     | out_valid_o / out_stall_i | kind, cross_x/y, near_dist_a/b
//
// One item is accepted per cycle while in_stall_o is low.
// The division cells give one quotient bit of t and s per cell,
// 2*COORD_BITS+17 cells, with the length square roots done in the first cells.
// Reset clears only the valid bits of each stage.
// The whole row freezes while a result waits at the output with out_stall_i high.
module segment_intersection_core
  import sic_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [COORD_BITS-1:0]   a_x0_i,
  input  logic [COORD_BITS-1:0]   a_y0_i,
  input  logic [COORD_BITS-1:0]   a_x1_i,
  input  logic [COORD_BITS-1:0]   a_y1_i,
  input  logic [COORD_BITS-1:0]   b_x0_i,
  input  logic [COORD_BITS-1:0]   b_y0_i,
  input  logic [COORD_BITS-1:0]   b_x1_i,
  input  logic [COORD_BITS-1:0]   b_y1_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              kind_o,
  output logic signed [OUT_W-1:0] cross_x_o,
  output logic signed [OUT_W-1:0] cross_y_o,
  output logic [OUT_W-1:0]        near_dist_a_o,
  output logic [OUT_W-1:0]        near_dist_b_o
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned DW  = 2*C+1;
  localparam int unsigned QW  = DW+T_FRAC;
  localparam int unsigned SW  = C+FRAC_BITS+1;
  localparam int unsigned SBW = 4*C+6;

  // Global advance: move unless a finished item is held at the output
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  logic            vld  [0:QW];
  logic [DW-1:0]   den  [0:QW];
  logic [DW-1:0]   trem [0:QW];
  logic [QW-1:0]   tnq  [0:QW];
  logic [DW-1:0]   srem [0:QW];
  logic [QW-1:0]   snq  [0:QW];
  logic [SW+1:0]   arem [0:QW];
  logic [2*SW-1:0] arad [0:QW];
  logic [SW-1:0]   aroot[0:QW];
  logic [SW+1:0]   brem [0:QW];
  logic [2*SW-1:0] brad [0:QW];
  logic [SW-1:0]   broot[0:QW];
  logic [SBW-1:0]  sb   [0:QW];

  sic_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .a_x0_i  (a_x0_i),
    .a_y0_i  (a_y0_i),
    .a_x1_i  (a_x1_i),
    .a_y1_i  (a_y1_i),
    .b_x0_i  (b_x0_i),
    .b_y0_i  (b_y0_i),
    .b_x1_i  (b_x1_i),
    .b_y1_i  (b_y1_i),
    .valid_o (vld[0]),
    .den_o   (den[0]),
    .tnum_o  (tnq[0]),
    .snum_o  (snq[0]),
    .rada_o  (arad[0]),
    .radb_o  (brad[0]),
    .sb_o    (sb[0])
  );

  // Partial remainders and roots start at zero
  assign trem[0]  = '0;
  assign srem[0]  = '0;
  assign arem[0]  = '0;
  assign aroot[0] = '0;
  assign brem[0]  = '0;
  assign broot[0] = '0;

  // Row of divide/root cells
  for (genvar i = 0; i < QW; i++) begin : g_cell
    sic_cell #(
      .DW      (DW),
      .QW      (QW),
      .SW      (SW),
      .SBW     (SBW),
      .SQRT_ON (i < SW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .valid_i  (vld[i]),
      .den_i    (den[i]),
      .t_rem_i  (trem[i]),
      .t_nq_i   (tnq[i]),
      .s_rem_i  (srem[i]),
      .s_nq_i   (snq[i]),
      .a_rem_i  (arem[i]),
      .a_rad_i  (arad[i]),
      .a_root_i (aroot[i]),
      .b_rem_i  (brem[i]),
      .b_rad_i  (brad[i]),
      .b_root_i (broot[i]),
      .sb_i     (sb[i]),
      .valid_o  (vld[i+1]),
      .den_o    (den[i+1]),
      .t_rem_o  (trem[i+1]),
      .t_nq_o   (tnq[i+1]),
      .s_rem_o  (srem[i+1]),
      .s_nq_o   (snq[i+1]),
      .a_rem_o  (arem[i+1]),
      .a_rad_o  (arad[i+1]),
      .a_root_o (aroot[i+1]),
      .b_rem_o  (brem[i+1]),
      .b_rad_o  (brad[i+1]),
      .b_root_o (broot[i+1]),
      .sb_o     (sb[i+1])
    );
  end

  sic_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .valid_i       (vld[QW]),
    .tq_i          (tnq[QW]),
    .sq_i          (snq[QW]),
    .lena_i        (aroot[QW]),
    .lenb_i        (broot[QW]),
    .sb_i          (sb[QW]),
    .valid_o       (out_valid_o),
    .kind_o        (kind_o),
    .cross_x_o     (cross_x_o),
    .cross_y_o     (cross_y_o),
    .near_dist_a_o (near_dist_a_o),
    .near_dist_b_o (near_dist_b_o)
  );

  // Input is held off only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A point inside both segments lies at nonnegative coordinates
  a_inside_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_INSIDE) |-> !cross_x_o[OUT_W-1])
    else $error("inside point with negative x");

  a_inside_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_INSIDE) |-> !cross_y_o[OUT_W-1])
    else $error("inside point with negative y");

endmodule
